[design/mcp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Maxwell characteristic projection package
// Shared widths, pipeline depths, the command encoding and the sideband
// record that travels next to the normal arithmetic.
// ---------------------------------------------------------------------------
package mcp_pkg;

   // Field format: signed Q15.16. The raw results do not depend on the split.
   localparam int DATA_W    = 32;
   // Unit normal components carry this many fraction bits.
   localparam int UNIT_BITS = 29;
   localparam int U_W       = UNIT_BITS + 2;
   localparam int Q_W       = UNIT_BITS + 1;
   localparam int D_W       = DATA_W + 2;
   localparam int ACC_W     = 64;
   localparam int PROD_W    = U_W + DATA_W;
   localparam int SQ_W      = 2 * DATA_W;
   localparam int ROOT_W    = DATA_W;
   localparam int SH_W      = 5;

   // Pipeline geometry.
   localparam int ISQ_STEPS = SQ_W / 2;
   localparam int DIV_STEPS = Q_W;
   localparam int DIV_LAT   = DIV_STEPS + 1;
   localparam int PIPE_LAT  = 5 + ISQ_STEPS + DIV_LAT + 7;
   localparam int NRM_DLY   = ISQ_STEPS + 2;
   localparam int SIDE_DLY  = 4 + ISQ_STEPS + DIV_LAT;
   localparam int U_DLY     = 3;

   typedef enum logic [1:0] {
      CMD_NEG      = 2'd0,
      CMD_NEG_NULL = 2'd1,
      CMD_POS      = 2'd2,
      CMD_POS_NULL = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic                    zero;
      logic [2:0]              neg;
      logic [2:0][DATA_W-1:0]  e;
      logic [2:0][DATA_W-1:0]  h;
   } side_type;

endpackage

[design/mcp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Maxwell characteristic projection channels
// Request channel (command, field state, face normal) and response channel
// (projected state and zero normal flag), both with valid/ready.
// ---------------------------------------------------------------------------
interface mcp_req_if;
   import mcp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic signed [DATA_W-1:0] ex;
   logic signed [DATA_W-1:0] ey;
   logic signed [DATA_W-1:0] ez;
   logic signed [DATA_W-1:0] hx;
   logic signed [DATA_W-1:0] hy;
   logic signed [DATA_W-1:0] hz;
   logic signed [DATA_W-1:0] normal_x;
   logic signed [DATA_W-1:0] normal_y;
   logic signed [DATA_W-1:0] normal_z;

   modport source (output valid, command, ex, ey, ez, hx, hy, hz,
                   normal_x, normal_y, normal_z, input ready);
   modport sink (input valid, command, ex, ey, ez, hx, hy, hz,
                 normal_x, normal_y, normal_z, output ready);
endinterface

interface mcp_rsp_if;
   import mcp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] proj_ex;
   logic signed [DATA_W-1:0] proj_ey;
   logic signed [DATA_W-1:0] proj_ez;
   logic signed [DATA_W-1:0] proj_hx;
   logic signed [DATA_W-1:0] proj_hy;
   logic signed [DATA_W-1:0] proj_hz;
   logic                     zero_normal;

   modport source (output valid, proj_ex, proj_ey, proj_ez, proj_hx, proj_hy,
                   proj_hz, zero_normal, input ready);
   modport sink (input valid, proj_ex, proj_ey, proj_ez, proj_hx, proj_hy,
                 proj_hz, zero_normal, output ready);
endinterface

[design/mcp_delay.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Enabled delay line
// Carries a payload vector through a fixed number of register stages that
// advance together with the arithmetic pipeline.
// ---------------------------------------------------------------------------
module mcp_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // Shift every tap by one stage when the pipeline advances.
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= data_in;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

[design/mcp_isqrt.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ---------------------------------------------------------------------------
module mcp_isqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [mcp_pkg::SQ_W-1:0]    radicand,
   output logic [mcp_pkg::ROOT_W-1:0]  root
);
   import mcp_pkg::*;

   logic [SQ_W-1:0] rem_ff  [ISQ_STEPS];
   logic [SQ_W-1:0] part_ff [ISQ_STEPS];

   for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      logic [SQ_W-1:0] rem_prev;
      logic [SQ_W-1:0] part_prev;
      logic [SQ_W-1:0] trial;
      logic [SQ_W-1:0] rem_in;
      logic [SQ_W-1:0] part_in;

      if (k == 0) begin : g_first
         assign rem_prev  = radicand;
         assign part_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign part_prev = part_ff[k-1];
      end

      // One restoring step: subtract the trial value when it fits.
      assign trial = part_prev + BIT;
      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            part_in = (part_prev >> 1) + BIT;
         end else begin
            rem_in  = rem_prev;
            part_in = part_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            part_ff[k] <= part_in;
         end
      end
   end

   assign root = part_ff[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

[design/mcp_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined unit normal divider
// Computes round(a * 2^UNIT_BITS / r) for a <= r, one quotient bit per stage.
// ---------------------------------------------------------------------------
module mcp_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [mcp_pkg::DATA_W-1:0] mag,
   input  logic [mcp_pkg::ROOT_W-1:0] root,
   output logic [mcp_pkg::Q_W-1:0]    quot
);
   import mcp_pkg::*;

   localparam int NUM_W = DATA_W + UNIT_BITS + 1;

   logic [NUM_W-1:0]  num_ff;
   logic [ROOT_W-1:0] den_ff;
   logic [NUM_W-1:0]  num_in;

   logic [ROOT_W-1:0] rem_ff [DIV_STEPS];
   logic [Q_W-1:0]    low_ff [DIV_STEPS];
   logic [Q_W-1:0]    quo_ff [DIV_STEPS];
   logic [ROOT_W-1:0] dv_ff  [DIV_STEPS];

   // Dividend with half the divisor added, so truncation rounds to nearest.
   assign num_in = (NUM_W'(mag) << UNIT_BITS) + NUM_W'(root >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= root;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [ROOT_W-1:0] rem_prev;
      logic [Q_W-1:0]    low_prev;
      logic [Q_W-1:0]    quo_prev;
      logic [ROOT_W-1:0] dv_prev;
      logic [ROOT_W:0]   trial;
      logic              fits;
      logic [ROOT_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev = num_ff[NUM_W-1:Q_W];
         assign low_prev = num_ff[Q_W-1:0];
         assign quo_prev = '0;
         assign dv_prev  = den_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign dv_prev  = dv_ff[k-1];
      end

      // Bring down the next dividend bit and try the subtraction.
      assign trial  = {rem_prev, low_prev[Q_W-1-k]};
      assign fits   = trial >= {1'b0, dv_prev};
      assign rem_in = fits ? ROOT_W'(trial - {1'b0, dv_prev}) : trial[ROOT_W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_prev;
            quo_ff[k] <= {quo_prev[Q_W-2:0], fits};
            dv_ff[k]  <= dv_prev;
         end
      end
   end

   assign quot = quo_ff[DIV_STEPS-1];

endmodule

[design/maxwell_characteristic_projection_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Maxwell characteristic projection core
// Projects a six-component electromagnetic state onto the negative or
// positive characteristic subspace of a face normal, optionally with the
// null space, in signed Q15.16 with rounding and saturation.
// ---------------------------------------------------------------------------
// Usage:
// A request transaction carries the command, the E and H components and a
// face normal of any length. Each request yields exactly one response
// transaction with the six projected components and a zero normal flag.
// The core is a fully pipelined datapath: a new request is taken in every
// cycle unless a stalled response freezes the pipeline.
// The depth is set by the 32-stage square root of |n|^2 and the 31-stage
// divider that forms the unit normal; the rest is normalization, the
// multiplier stages and rounding.
// A zero normal gives zero components with zero_normal set.
// Reset (synchronous, active high) empties the pipeline; no response is
// pending afterwards. When the receiver holds rsp_chan.ready low while a
// response waits, the whole pipeline freezes and req_chan.ready drops in
// the same cycle, so no transaction is lost or repeated.
// ---------------------------------------------------------------------------
module maxwell_characteristic_projection_core (
   input logic         clock,
   input logic         reset,
   mcp_req_if.sink     req_chan,
   mcp_rsp_if.source   rsp_chan
);
   import mcp_pkg::*;

   localparam int SIDE_W = $bits(side_type);

   // Shift needed to bring the leading one of a magnitude up to bit 30.
   function automatic logic [SH_W-1:0] norm_shift(input logic [DATA_W-1:0] m);
      logic [SH_W-1:0] sh;
      logic            found;
      sh    = '0;
      found = 1'b0;
      for (int i = DATA_W - 2; i >= 0; i--) begin
         if (!found && m[i]) begin
            sh    = SH_W'(DATA_W - 2 - i);
            found = 1'b1;
         end
      end
      if (m[DATA_W-1]) begin
         sh = '0;
      end
      return sh;
   endfunction

   // Pipeline advance and valid tracking.
   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;

   assign en             = !vld_ff[PIPE_LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_chan.valid};
      end
   end

   // Stage A: capture, magnitudes, signs and zero detection.
   logic signed [DATA_W-1:0] req_n [3];
   logic [DATA_W-1:0]        a_mag_in [3];
   logic [DATA_W-1:0]        a_mag_ff [3];
   side_type                 a_side_in;
   side_type                 a_side_ff;

   assign req_n[0] = req_chan.normal_x;
   assign req_n[1] = req_chan.normal_y;
   assign req_n[2] = req_chan.normal_z;

   always_comb begin
      a_side_in.cmd  = cmd_type'(req_chan.command);
      a_side_in.zero = (req_n[0] == '0) && (req_n[1] == '0) && (req_n[2] == '0);
      a_side_in.e    = {req_chan.ez, req_chan.ey, req_chan.ex};
      a_side_in.h    = {req_chan.hz, req_chan.hy, req_chan.hx};
      for (int i = 0; i < 3; i++) begin
         a_side_in.neg[i] = req_n[i][DATA_W-1];
         a_mag_in[i]      = req_n[i][DATA_W-1] ? DATA_W'(-req_n[i]) : DATA_W'(req_n[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= a_side_in;
         a_mag_ff  <= a_mag_in;
      end
   end

   // Stage B: normalization shift from the combined leading one.
   logic [SH_W-1:0]   b_sh_ff;
   logic [DATA_W-1:0] b_mag_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         b_sh_ff  <= norm_shift(a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2]);
         b_mag_ff <= a_mag_ff;
      end
   end

   // Stage C: scale the normal up so the root keeps full precision.
   logic [DATA_W-1:0] c_mag_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c_mag_ff[i] <= b_mag_ff[i] << b_sh_ff;
         end
      end
   end

   // Stage D: squares of the scaled components.
   logic [SQ_W-1:0] d_sq_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= SQ_W'(c_mag_ff[i]) * SQ_W'(c_mag_ff[i]);
         end
      end
   end

   // Stage E: squared length.
   logic [SQ_W-1:0] e_sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e_sum_ff <= d_sq_ff[0] + d_sq_ff[1] + d_sq_ff[2];
      end
   end

   // Square root, then the three divisions that form the unit normal.
   logic [ROOT_W-1:0]   root;
   logic [3*DATA_W-1:0] mag_dly;
   logic [Q_W-1:0]      quot [3];

   mcp_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (e_sum_ff),
      .root     (root)
   );

   mcp_delay #(
      .WIDTH (3 * DATA_W),
      .DEPTH (NRM_DLY)
   ) u_mag_dly (
      .clock    (clock),
      .en       (en),
      .data_in  ({c_mag_ff[2], c_mag_ff[1], c_mag_ff[0]}),
      .data_out (mag_dly)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      mcp_div u_div (
         .clock (clock),
         .en    (en),
         .mag   (mag_dly[i*DATA_W +: DATA_W]),
         .root  (root),
         .quot  (quot[i])
      );
   end

   // Sideband from stage A to the unit normal stage.
   logic [SIDE_W-1:0] side_dly;

   mcp_delay #(
      .WIDTH (SIDE_W),
      .DEPTH (SIDE_DLY)
   ) u_side_dly (
      .clock    (clock),
      .en       (en),
      .data_in  (a_side_ff),
      .data_out (side_dly)
   );

   // Stage G: signed unit normal.
   logic signed [U_W-1:0] g_u_ff [3];
   side_type              g_side_ff;
   side_type              side_g;

   assign side_g = side_type'(side_dly);

   always_ff @(posedge clock) begin
      if (en) begin
         g_side_ff <= side_g;
         for (int i = 0; i < 3; i++) begin
            g_u_ff[i] <= side_g.neg[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
         end
      end
   end

   // Stage H: dot and cross product partial products.
   logic signed [PROD_W-1:0] h_pe_ff [3];
   logic signed [PROD_W-1:0] h_ph_ff [3];
   logic signed [PROD_W-1:0] h_xh_a_ff [3];
   logic signed [PROD_W-1:0] h_xh_b_ff [3];
   logic signed [PROD_W-1:0] h_xe_a_ff [3];
   logic signed [PROD_W-1:0] h_xe_b_ff [3];
   logic signed [DATA_W-1:0] g_e [3];
   logic signed [DATA_W-1:0] g_h [3];
   side_type                 h_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_e[i] = $signed(g_side_ff.e[i]);
         g_h[i] = $signed(g_side_ff.h[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_side_ff <= g_side_ff;
         for (int i = 0; i < 3; i++) begin
            h_pe_ff[i]   <= PROD_W'(g_u_ff[i]) * PROD_W'(g_e[i]);
            h_ph_ff[i]   <= PROD_W'(g_u_ff[i]) * PROD_W'(g_h[i]);
            h_xh_a_ff[i] <= PROD_W'(g_u_ff[(i+1)%3]) * PROD_W'(g_h[(i+2)%3]);
            h_xh_b_ff[i] <= PROD_W'(g_u_ff[(i+2)%3]) * PROD_W'(g_h[(i+1)%3]);
            h_xe_a_ff[i] <= PROD_W'(g_u_ff[(i+1)%3]) * PROD_W'(g_e[(i+2)%3]);
            h_xe_b_ff[i] <= PROD_W'(g_u_ff[(i+2)%3]) * PROD_W'(g_e[(i+1)%3]);
         end
      end
   end

   // Stage I: dot sums and cross products.
   logic signed [ACC_W-1:0] i_se_ff;
   logic signed [ACC_W-1:0] i_sh_ff;
   logic signed [ACC_W-1:0] i_cxh_ff [3];
   logic signed [ACC_W-1:0] i_cxe_ff [3];
   side_type                i_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         i_side_ff <= h_side_ff;
         i_se_ff   <= ACC_W'(h_pe_ff[0]) + ACC_W'(h_pe_ff[1]) + ACC_W'(h_pe_ff[2]);
         i_sh_ff   <= ACC_W'(h_ph_ff[0]) + ACC_W'(h_ph_ff[1]) + ACC_W'(h_ph_ff[2]);
         for (int i = 0; i < 3; i++) begin
            i_cxh_ff[i] <= ACC_W'(h_xh_a_ff[i]) - ACC_W'(h_xh_b_ff[i]);
            i_cxe_ff[i] <= ACC_W'(h_xe_a_ff[i]) - ACC_W'(h_xe_b_ff[i]);
         end
      end
   end

   // Stage J: round the normal components of E and H, half away from zero.
   localparam logic signed [ACC_W-1:0] HALF_U = ACC_W'(1) <<< (UNIT_BITS - 1);

   logic signed [ACC_W-1:0] j_de_in;
   logic signed [ACC_W-1:0] j_dh_in;
   logic signed [D_W-1:0]   j_de_ff;
   logic signed [D_W-1:0]   j_dh_ff;
   logic signed [ACC_W-1:0] j_cxh_ff [3];
   logic signed [ACC_W-1:0] j_cxe_ff [3];
   side_type                j_side_ff;

   assign j_de_in = (i_se_ff + HALF_U - $signed({{(ACC_W-1){1'b0}}, i_se_ff[ACC_W-1]}))
                    >>> UNIT_BITS;
   assign j_dh_in = (i_sh_ff + HALF_U - $signed({{(ACC_W-1){1'b0}}, i_sh_ff[ACC_W-1]}))
                    >>> UNIT_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         j_side_ff <= i_side_ff;
         j_de_ff   <= j_de_in[D_W-1:0];
         j_dh_ff   <= j_dh_in[D_W-1:0];
         j_cxh_ff  <= i_cxh_ff;
         j_cxe_ff  <= i_cxe_ff;
      end
   end

   // The unit normal again, for the normal-direction terms.
   logic [3*U_W-1:0]      u_dly;
   logic signed [U_W-1:0] j_u [3];

   mcp_delay #(
      .WIDTH (3 * U_W),
      .DEPTH (U_DLY)
   ) u_unit_dly (
      .clock    (clock),
      .en       (en),
      .data_in  ({g_u_ff[2], g_u_ff[1], g_u_ff[0]}),
      .data_out (u_dly)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         j_u[i] = $signed(u_dly[i*U_W +: U_W]);
      end
   end

   // Stage K: normal-direction terms u_i * d.
   logic signed [U_W+D_W-1:0] k_ude_in [3];
   logic signed [U_W+D_W-1:0] k_udh_in [3];
   logic signed [ACC_W-1:0]   k_ude_ff [3];
   logic signed [ACC_W-1:0]   k_udh_ff [3];
   logic signed [ACC_W-1:0]   k_cxh_ff [3];
   logic signed [ACC_W-1:0]   k_cxe_ff [3];
   side_type                  k_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         k_ude_in[i] = (U_W+D_W)'(j_u[i]) * (U_W+D_W)'(j_de_ff);
         k_udh_in[i] = (U_W+D_W)'(j_u[i]) * (U_W+D_W)'(j_dh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_side_ff <= j_side_ff;
         k_cxh_ff  <= j_cxh_ff;
         k_cxe_ff  <= j_cxe_ff;
         for (int i = 0; i < 3; i++) begin
            k_ude_ff[i] <= k_ude_in[i][ACC_W-1:0];
            k_udh_ff[i] <= k_udh_in[i][ACC_W-1:0];
         end
      end
   end

   // Stage L: combine the identity, normal and cross terms.
   logic                    keep_null;
   logic                    positive;
   logic signed [ACC_W-1:0] l_ve_in [3];
   logic signed [ACC_W-1:0] l_vh_in [3];
   logic signed [ACC_W-1:0] l_ve_ff [3];
   logic signed [ACC_W-1:0] l_vh_ff [3];
   logic                    l_zero_ff;

   assign keep_null = (k_side_ff.cmd == CMD_NEG_NULL) || (k_side_ff.cmd == CMD_POS_NULL);
   assign positive  = (k_side_ff.cmd == CMD_POS) || (k_side_ff.cmd == CMD_POS_NULL);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         l_ve_in[i] = (ACC_W'($signed(k_side_ff.e[i])) <<< UNIT_BITS)
                      + (keep_null ? k_ude_ff[i] : -k_ude_ff[i])
                      + (positive ? -k_cxh_ff[i] : k_cxh_ff[i]);
         l_vh_in[i] = (ACC_W'($signed(k_side_ff.h[i])) <<< UNIT_BITS)
                      + (keep_null ? k_udh_ff[i] : -k_udh_ff[i])
                      + (positive ? k_cxe_ff[i] : -k_cxe_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_ve_ff   <= l_ve_in;
         l_vh_ff   <= l_vh_in;
         l_zero_ff <= k_side_ff.zero;
      end
   end

   // Stage M: halve with rounding, saturate, force zero for a null normal.
   localparam logic signed [ACC_W-1:0] HALF_O = ACC_W'(1) <<< UNIT_BITS;
   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (DATA_W - 1)) - 1;
   localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (DATA_W - 1));

   logic signed [ACC_W-1:0]  m_rnd [6];
   logic signed [DATA_W-1:0] m_res_in [6];
   logic signed [DATA_W-1:0] m_res_ff [6];
   logic                     m_zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_rnd[i]   = (l_ve_ff[i] + HALF_O
                       - $signed({{(ACC_W-1){1'b0}}, l_ve_ff[i][ACC_W-1]})) >>> (UNIT_BITS + 1);
         m_rnd[3+i] = (l_vh_ff[i] + HALF_O
                       - $signed({{(ACC_W-1){1'b0}}, l_vh_ff[i][ACC_W-1]})) >>> (UNIT_BITS + 1);
      end
      for (int i = 0; i < 6; i++) begin
         if (l_zero_ff) begin
            m_res_in[i] = '0;
         end else if (m_rnd[i] > SAT_HI) begin
            m_res_in[i] = SAT_HI[DATA_W-1:0];
         end else if (m_rnd[i] < SAT_LO) begin
            m_res_in[i] = SAT_LO[DATA_W-1:0];
         end else begin
            m_res_in[i] = m_rnd[i][DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_res_ff  <= m_res_in;
         m_zero_ff <= l_zero_ff;
      end
   end

   assign rsp_chan.proj_ex     = m_res_ff[0];
   assign rsp_chan.proj_ey     = m_res_ff[1];
   assign rsp_chan.proj_ez     = m_res_ff[2];
   assign rsp_chan.proj_hx     = m_res_ff[3];
   assign rsp_chan.proj_hy     = m_res_ff[4];
   assign rsp_chan.proj_hz     = m_res_ff[5];
   assign rsp_chan.zero_normal = m_zero_ff;

   // A flagged zero normal always comes with all-zero components.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_normal |->
         rsp_chan.proj_ex == '0 && rsp_chan.proj_ey == '0 && rsp_chan.proj_ez == '0 &&
         rsp_chan.proj_hx == '0 && rsp_chan.proj_hy == '0 && rsp_chan.proj_hz == '0)
      else $error("zero normal response carries nonzero components");

   // A stalled response freezes the pipeline and blocks new requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted while the response is stalled");

   // An accepted request enters the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule
